// ----- design/qbp_pkg.sv -----
// ----------------------------------------------------------------------------
// qbp_pkg: shared types and constants for quadtree box placement
// Item layouts, register indexes, quadrant codes and edge arithmetic helpers.
// ----------------------------------------------------------------------------
package qbp_pkg;

  localparam int EDGE_W    = 24;
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 8;
  localparam int OUT_LVL_W = 4;
  localparam int LVL_W     = 5;   // holds depths up to 31
  localparam int PATH_W    = 16;
  localparam int QUAD_W    = 2;
  localparam int PATH_SLOTS = PATH_W / QUAD_W;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 3'd4;

  localparam edge_t ROOT_LOW_RST  = -24'sd2000;
  localparam edge_t ROOT_HIGH_RST = 24'sd2000;

  // Quadrant codes in test order
  localparam logic [QUAD_W-1:0] QUAD_LX_LY = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_HX_LY = 2'd1;
  localparam logic [QUAD_W-1:0] QUAD_LX_HY = 2'd2;
  localparam logic [QUAD_W-1:0] QUAD_HX_HY = 2'd3;

  typedef struct packed {
    logic   has_box;
    coord_t box_x_low;
    coord_t box_x_high;
    coord_t box_y_low;
    coord_t box_y_high;
  } box_item_t;

  typedef struct packed {
    logic [OUT_LVL_W-1:0] placed_level;
    logic [PATH_W-1:0]    quadrant_path;
  } place_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [EDGE_W-1:0]    data;
  } cfg_item_t;

  typedef struct packed {
    edge_t                root_x_low;
    edge_t                root_x_high;
    edge_t                root_y_low;
    edge_t                root_y_high;
    logic [OUT_LVL_W-1:0] lvl_limit;
  } cfg_regs_t;

  // Descent state carried from cell to cell
  typedef struct packed {
    logic              active;
    logic [LVL_W-1:0]  level;
    logic [PATH_W-1:0] path;
    edge_t             nx0;
    edge_t             nx1;
    edge_t             ny0;
    edge_t             ny1;
    coord_t            bx0;
    coord_t            bx1;
    coord_t            by0;
    coord_t            by1;
  } node_t;

  // Half the edge sum, truncated toward zero
  function automatic edge_t midpoint(edge_t a, edge_t b);
    logic [EDGE_W:0] s;
    s = {a[EDGE_W-1], a} + {b[EDGE_W-1], b};
    if (s[EDGE_W] && s[0]) begin
      s = s + 1'b1;
    end
    return edge_t'(s[EDGE_W:1]);
  endfunction

  // Integer edge to box fixed point
  function automatic coord_t scale(edge_t e);
    return coord_t'({e, {FRAC_W{1'b0}}});
  endfunction

endpackage

// ----- design/qbp_if.sv -----
// ----------------------------------------------------------------------------
// qbp interfaces: valid/ready channels of quadtree box placement
// Box input channel, placement result channel and register write channel.
// ----------------------------------------------------------------------------
interface qbp_box_if;
  logic               valid;
  logic               ready;
  qbp_pkg::box_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface qbp_place_if;
  logic                 valid;
  logic                 ready;
  qbp_pkg::place_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface qbp_cfg_if;
  logic               valid;
  logic               ready;
  qbp_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/qbp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// qbp_cfg_regs: configuration registers
// Root square edges and depth limit, written through the register channel.
// ----------------------------------------------------------------------------
module qbp_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  qbp_cfg_if.sink            cfg_i,
  output qbp_pkg::cfg_regs_t regs_o
);

  qbp_pkg::cfg_regs_t regs_q;

  // Always take writes
  assign cfg_i.ready = 1'b1;

  // Decode and store writes; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.root_x_low  <= qbp_pkg::ROOT_LOW_RST;
      regs_q.root_x_high <= qbp_pkg::ROOT_HIGH_RST;
      regs_q.root_y_low  <= qbp_pkg::ROOT_LOW_RST;
      regs_q.root_y_high <= qbp_pkg::ROOT_HIGH_RST;
      regs_q.lvl_limit   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        qbp_pkg::REG_ROOT_X_LOW:  regs_q.root_x_low  <= cfg_i.payload.data;
        qbp_pkg::REG_ROOT_X_HIGH: regs_q.root_x_high <= cfg_i.payload.data;
        qbp_pkg::REG_ROOT_Y_LOW:  regs_q.root_y_low  <= cfg_i.payload.data;
        qbp_pkg::REG_ROOT_Y_HIGH: regs_q.root_y_high <= cfg_i.payload.data;
        qbp_pkg::REG_MAX_LEVEL: begin
          regs_q.lvl_limit <= cfg_i.payload.data[qbp_pkg::OUT_LVL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

// ----- design/qbp_cell.sv -----
// ----------------------------------------------------------------------------
// qbp_cell: one descent step of the placement chain
// Splits the current node, picks the first quadrant holding the box, and
// hands the refined node to the next cell.
// ----------------------------------------------------------------------------
module qbp_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [qbp_pkg::LVL_W-1:0]   limit_i,
  input  logic                        valid_i,
  input  qbp_pkg::node_t              node_i,
  output logic                        valid_o,
  output qbp_pkg::node_t              node_o
);

  qbp_pkg::edge_t  mx, my;
  qbp_pkg::coord_t s_nx0, s_nx1, s_ny0, s_ny1, s_mx, s_my;
  logic            xl_in, xl_mid, xh_mid, xh_in;
  logic            yl_in, yl_mid, yh_mid, yh_in;
  logic            q0, q1, q2, q3;
  logic            step;
  logic [qbp_pkg::QUAD_W-1:0] quad;
  qbp_pkg::node_t  node_d, node_q;
  logic            valid_q;

  // Split the node and scale edges to box units
  always_comb begin
    mx    = qbp_pkg::midpoint(node_i.nx0, node_i.nx1);
    my    = qbp_pkg::midpoint(node_i.ny0, node_i.ny1);
    s_nx0 = qbp_pkg::scale(node_i.nx0);
    s_nx1 = qbp_pkg::scale(node_i.nx1);
    s_ny0 = qbp_pkg::scale(node_i.ny0);
    s_ny1 = qbp_pkg::scale(node_i.ny1);
    s_mx  = qbp_pkg::scale(mx);
    s_my  = qbp_pkg::scale(my);
  end

  // Edge tests shared by the four quadrants
  always_comb begin
    xl_in  = node_i.bx0 >= s_nx0;
    xl_mid = node_i.bx0 >= s_mx;
    xh_mid = node_i.bx1 <= s_mx;
    xh_in  = node_i.bx1 <= s_nx1;
    yl_in  = node_i.by0 >= s_ny0;
    yl_mid = node_i.by0 >= s_my;
    yh_mid = node_i.by1 <= s_my;
    yh_in  = node_i.by1 <= s_ny1;
    q0 = xl_in  && xh_mid && yl_in  && yh_mid;
    q1 = xl_mid && xh_in  && yl_in  && yh_mid;
    q2 = xl_in  && xh_mid && yl_mid && yh_in;
    q3 = xl_mid && xh_in  && yl_mid && yh_in;
  end

  // Enter the first containing quadrant or stop descending
  always_comb begin
    node_d = node_i;
    quad   = qbp_pkg::QUAD_LX_LY;
    step   = node_i.active && (node_i.level < limit_i) && (q0 || q1 || q2 || q3);
    if (q0) begin
      quad = qbp_pkg::QUAD_LX_LY;
    end else if (q1) begin
      quad = qbp_pkg::QUAD_HX_LY;
    end else if (q2) begin
      quad = qbp_pkg::QUAD_LX_HY;
    end else begin
      quad = qbp_pkg::QUAD_HX_HY;
    end
    if (step) begin
      case (quad)
        qbp_pkg::QUAD_LX_LY: begin
          node_d.nx1 = mx;
          node_d.ny1 = my;
        end
        qbp_pkg::QUAD_HX_LY: begin
          node_d.nx0 = mx;
          node_d.ny1 = my;
        end
        qbp_pkg::QUAD_LX_HY: begin
          node_d.nx1 = mx;
          node_d.ny0 = my;
        end
        default: begin
          node_d.nx0 = mx;
          node_d.ny0 = my;
        end
      endcase
      // Levels past the path width are dropped
      for (int k = 0; k < qbp_pkg::PATH_SLOTS; k++) begin
        if (node_i.level == qbp_pkg::LVL_W'(k)) begin
          node_d.path[k*qbp_pkg::QUAD_W +: qbp_pkg::QUAD_W] = quad;
        end
      end
      node_d.level = node_i.level + 1'b1;
    end else begin
      node_d.active = 1'b0;
    end
  end

  // Valid bit of the cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Node payload of the cell
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      node_q <= node_d;
    end
  end

  assign valid_o = valid_q;
  assign node_o  = node_q;

endmodule

// ----- design/quadtree_box_placement_core.sv -----
// ----------------------------------------------------------------------------
// quadtree_box_placement_core: deepest quadtree node holding a box
// Chain of descent cells, one quadtree level per cell.
// ----------------------------------------------------------------------------
// Usage:
//   box_i    carries one bounding box per item (has_box plus low and high
//            edges on both axes, signed fixed point with 8 fraction bits).
//   place_o  returns one item per box: placed_level and quadrant_path.
//   cfg_i    writes the root square edges and the depth limit by register
//            index; write only while no box is in flight.
// A box passes through the chain of MAX_DEPTH descent cells, each
// registered. A new box is taken every cycle while place_o is not stalled,
// so throughput is one item per cycle.
// When place_o is stalled the whole chain holds and box_i.ready drops in
// the same cycle; nothing is lost and the pending result stays on place_o.
// Reset clears every cell's valid bit and loads the register reset values
// (root -2000..2000 on both axes, depth limit 0); no clearing pass is needed.
// ----------------------------------------------------------------------------
module quadtree_box_placement_core #(
  parameter int MAX_DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qbp_box_if.sink       box_i,
  qbp_place_if.source   place_o,
  qbp_cfg_if.sink       cfg_i
);

  qbp_pkg::cfg_regs_t regs;
  logic [qbp_pkg::LVL_W-1:0] limit;
  logic adv;
  logic           valid_s [MAX_DEPTH+1];
  qbp_pkg::node_t node_s  [MAX_DEPTH+1];

  qbp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // Clip the depth limit to the chain length
  always_comb begin
    if ({1'b0, regs.lvl_limit} > qbp_pkg::LVL_W'(MAX_DEPTH)) begin
      limit = qbp_pkg::LVL_W'(MAX_DEPTH);
    end else begin
      limit = {1'b0, regs.lvl_limit};
    end
  end

  // Advance the chain unless the result is stalled
  assign adv         = !place_o.valid || place_o.ready;
  assign box_i.ready = adv;

  // Build the root node from the incoming item
  always_comb begin
    valid_s[0]        = box_i.valid;
    node_s[0].active  = box_i.payload.has_box;
    node_s[0].level   = '0;
    node_s[0].path    = '0;
    node_s[0].nx0     = regs.root_x_low;
    node_s[0].nx1     = regs.root_x_high;
    node_s[0].ny0     = regs.root_y_low;
    node_s[0].ny1     = regs.root_y_high;
    node_s[0].bx0     = box_i.payload.box_x_low;
    node_s[0].bx1     = box_i.payload.box_x_high;
    node_s[0].by0     = box_i.payload.box_y_low;
    node_s[0].by1     = box_i.payload.box_y_high;
  end

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    qbp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .limit_i (limit),
      .valid_i (valid_s[i]),
      .node_i  (node_s[i]),
      .valid_o (valid_s[i+1]),
      .node_o  (node_s[i+1])
    );
  end

  // Present the last cell as the result
  assign place_o.valid = valid_s[MAX_DEPTH];
  assign place_o.payload.placed_level =
    node_s[MAX_DEPTH].level[qbp_pkg::OUT_LVL_W-1:0];
  assign place_o.payload.quadrant_path = node_s[MAX_DEPTH].path;

endmodule

// ----- design/qbp_checker.sv -----
// ----------------------------------------------------------------------------
// qbp_checker: port-level checks for quadtree box placement
// Watches the box and result channels of the top level over time.
// ----------------------------------------------------------------------------
module qbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  out_level_i,
  input logic [15:0] out_path_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Keep a stalled result unchanged
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_level_i) && $stable(out_path_i))
    else $error("stalled result changed");

  // Take boxes whenever no result is pending
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // Leave path bits beyond the placed level at zero
  a_path_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_level_i < 4'd8 |-> (out_path_i >> (2 * out_level_i)) == 16'd0)
    else $error("quadrant bits set beyond placed level");

endmodule

bind quadtree_box_placement_core qbp_checker u_qbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (box_i.valid),
  .in_ready_i  (box_i.ready),
  .out_valid_i (place_o.valid),
  .out_ready_i (place_o.ready),
  .out_level_i (place_o.payload.placed_level),
  .out_path_i  (place_o.payload.quadrant_path)
);

// ----- verif/qbp_place_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qbp_place_checker: placement predictor and scoreboard
// Watches the box, placement and register channels of the quadtree placement
// core, keeps its own copy of the root square and depth limit, works out the
// node each accepted box lands in and compares every returned placement with
// the oldest outstanding one.
// ----------------------------------------------------------------------------
module qbp_place_checker #(
  parameter int MAX_DEPTH = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  qbp_box_if    box_mon,
  qbp_place_if  place_mon,
  qbp_cfg_if    cfg_mon,
  output int    fail_count_o,
  output int    pending_o
);

  localparam int     REPORT_LIMIT = 10;
  localparam longint EDGE_SCALE   = longint'(1) << qbp_pkg::FRAC_W;

  qbp_pkg::cfg_regs_t   regs;
  qbp_pkg::place_item_t placements_q[$];
  int                   n_fail;

  // Inclusive containment of a box in a node, node edges scaled to fixed point
  function automatic bit fits(longint bx0, longint bx1, longint by0, longint by1,
                              longint nx0, longint nx1, longint ny0, longint ny1);
    return bx0 >= nx0 * EDGE_SCALE && bx1 <= nx1 * EDGE_SCALE &&
           by0 >= ny0 * EDGE_SCALE && by1 <= ny1 * EDGE_SCALE;
  endfunction

  // Descend from the root and return the deepest node holding the box
  function automatic qbp_pkg::place_item_t locate_node(qbp_pkg::box_item_t b,
                                                       qbp_pkg::cfg_regs_t r);
    qbp_pkg::place_item_t       res;
    longint                     bx0, bx1, by0, by1;
    longint                     nx0, nx1, ny0, ny1, mx, my;
    int                         limit;
    int                         lvl;
    logic [31:0]                path;
    logic [qbp_pkg::QUAD_W-1:0] quad;
    bit                         hit;
    bx0   = longint'(b.box_x_low);
    bx1   = longint'(b.box_x_high);
    by0   = longint'(b.box_y_low);
    by1   = longint'(b.box_y_high);
    nx0   = longint'(r.root_x_low);
    nx1   = longint'(r.root_x_high);
    ny0   = longint'(r.root_y_low);
    ny1   = longint'(r.root_y_high);
    limit = (int'(r.lvl_limit) > MAX_DEPTH) ? MAX_DEPTH : int'(r.lvl_limit);
    lvl   = 0;
    path  = '0;
    if (b.has_box) begin
      while (lvl < limit) begin
        // midpoints truncate toward zero
        mx  = (nx0 + nx1) / 2;
        my  = (ny0 + ny1) / 2;
        hit = 1'b1;
        if (fits(bx0, bx1, by0, by1, nx0, mx, ny0, my)) begin
          quad = qbp_pkg::QUAD_LX_LY;
          nx1  = mx;
          ny1  = my;
        end else if (fits(bx0, bx1, by0, by1, mx, nx1, ny0, my)) begin
          quad = qbp_pkg::QUAD_HX_LY;
          nx0  = mx;
          ny1  = my;
        end else if (fits(bx0, bx1, by0, by1, nx0, mx, my, ny1)) begin
          quad = qbp_pkg::QUAD_LX_HY;
          nx1  = mx;
          ny0  = my;
        end else if (fits(bx0, bx1, by0, by1, mx, nx1, my, ny1)) begin
          quad = qbp_pkg::QUAD_HX_HY;
          nx0  = mx;
          ny0  = my;
        end else begin
          hit = 1'b0;
        end
        if (!hit) break;
        if (2 * lvl < 32) path = path | (32'(quad) << (2 * lvl));
        lvl++;
      end
    end
    res.placed_level  = qbp_pkg::OUT_LVL_W'(lvl);
    res.quadrant_path = path[qbp_pkg::PATH_W-1:0];
    return res;
  endfunction

  // Track register writes, queue predictions, compare returned placements
  always @(posedge clk_i or negedge rst_ni) begin
    qbp_pkg::place_item_t got;
    qbp_pkg::place_item_t want;
    if (!rst_ni) begin
      regs.root_x_low  = qbp_pkg::ROOT_LOW_RST;
      regs.root_x_high = qbp_pkg::ROOT_HIGH_RST;
      regs.root_y_low  = qbp_pkg::ROOT_LOW_RST;
      regs.root_y_high = qbp_pkg::ROOT_HIGH_RST;
      regs.lvl_limit   = '0;
      placements_q.delete();
      n_fail        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.payload.index)
          qbp_pkg::REG_ROOT_X_LOW:
            regs.root_x_low  = qbp_pkg::edge_t'(cfg_mon.payload.data);
          qbp_pkg::REG_ROOT_X_HIGH:
            regs.root_x_high = qbp_pkg::edge_t'(cfg_mon.payload.data);
          qbp_pkg::REG_ROOT_Y_LOW:
            regs.root_y_low  = qbp_pkg::edge_t'(cfg_mon.payload.data);
          qbp_pkg::REG_ROOT_Y_HIGH:
            regs.root_y_high = qbp_pkg::edge_t'(cfg_mon.payload.data);
          qbp_pkg::REG_MAX_LEVEL:
            regs.lvl_limit   = cfg_mon.payload.data[qbp_pkg::OUT_LVL_W-1:0];
          default: ;
        endcase
      end
      if (box_mon.valid && box_mon.ready) begin
        placements_q = {placements_q, locate_node(box_mon.payload, regs)};
      end
      if (place_mon.valid && place_mon.ready) begin
        got = place_mon.payload;
        if (placements_q.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_LIMIT) begin
            $display("placement item with nothing outstanding: level %0d path %04h",
                     got.placed_level, got.quadrant_path);
          end
        end else begin
          want = placements_q.pop_front();
          if (got.placed_level !== want.placed_level ||
              got.quadrant_path !== want.quadrant_path) begin
            n_fail++;
            if (n_fail <= REPORT_LIMIT) begin
              $display("placement mismatch: expected level %0d path %04h, got level %0d path %04h",
                       want.placed_level, want.quadrant_path,
                       got.placed_level, got.quadrant_path);
            end
          end
        end
      end
      fail_count_o <= n_fail;
      pending_o    <= placements_q.size();
    end
  end

endmodule

// ----- verif/tb_quadtree_box_placement_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadtree_box_placement_core: stimulus and verdict for placement core
// Drives boxes and register writes into the core, stalls the result side at
// random, and leaves prediction and comparison to the placement checker.
// Directed corner, edge and extreme boxes come first, then random phases of
// boxes built to land in chosen nodes, straddle node borders or be noise.
// ----------------------------------------------------------------------------
module tb_quadtree_box_placement_core;

  localparam int     MAX_DEPTH       = 8;
  localparam int     RAND_PHASES     = 8;
  localparam int     ITEMS_PER_PHASE = 216;
  localparam int     HOLD_CYCLES     = 400;
  localparam int     WATCHDOG_LIMIT  = 4000;
  localparam longint EDGE_MIN        = -(longint'(1) << (qbp_pkg::EDGE_W - 1));
  localparam longint EDGE_MAX        = (longint'(1) << (qbp_pkg::EDGE_W - 1)) - 1;
  localparam longint COORD_MIN       = -(longint'(1) << (qbp_pkg::COORD_W - 1));
  localparam longint COORD_MAX       = (longint'(1) << (qbp_pkg::COORD_W - 1)) - 1;
  localparam longint EDGE_SCALE      = longint'(1) << qbp_pkg::FRAC_W;
  localparam int     LEVEL_ALL_ONES  = (1 << qbp_pkg::OUT_LVL_W) - 1;
  localparam logic [qbp_pkg::CFG_IDX_W-1:0] REG_SPARE = qbp_pkg::REG_MAX_LEVEL + 1'b1;

  typedef enum int {SHAPE_NODE, SHAPE_STRADDLE, SHAPE_WILD, SHAPE_EMPTY} box_shape_e;

  logic clk_i;
  logic rst_ni;
  int   chk_fails;
  int   chk_pending;
  int   quiet_cycles;
  bit   hold_off_req;
  bit   calm;

  // root square the core currently holds, as integers
  longint cx0 = -2000;
  longint cx1 = 2000;
  longint cy0 = -2000;
  longint cy1 = 2000;

  qbp_box_if   box_if ();
  qbp_place_if place_if ();
  qbp_cfg_if   cfg_if ();

  quadtree_box_placement_core #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_if),
    .place_o (place_if),
    .cfg_i   (cfg_if)
  );

  qbp_place_checker #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .box_mon      (box_if),
    .place_mon    (place_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Uniform value in [lo, hi]
  function automatic longint rand_span(longint lo, longint hi);
    longint unsigned r;
    longint unsigned span;
    if (hi <= lo) return lo;
    r    = {$urandom, $urandom};
    span = longint'(hi - lo) + 1;
    return lo + longint'(r % span);
  endfunction

  function automatic longint rand_coord();
    return longint'(int'($urandom));
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Favor the node edges themselves, since containment is inclusive
  function automatic longint pick_in(longint lo, longint hi);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return rand_span(lo, hi);
  endfunction

  function automatic qbp_pkg::box_item_t pack_box(bit has, longint x0, longint x1,
                                                  longint y0, longint y1);
    qbp_pkg::box_item_t b;
    b.has_box    = has;
    b.box_x_low  = qbp_pkg::coord_t'(x0);
    b.box_x_high = qbp_pkg::coord_t'(x1);
    b.box_y_low  = qbp_pkg::coord_t'(y0);
    b.box_y_high = qbp_pkg::coord_t'(y1);
    return b;
  endfunction

  // One register write item
  function automatic qbp_pkg::cfg_item_t cfg_word(logic [qbp_pkg::CFG_IDX_W-1:0] idx,
                                                  logic [qbp_pkg::EDGE_W-1:0] data);
    qbp_pkg::cfg_item_t w;
    w.index = idx;
    w.data  = data;
    return w;
  endfunction

  // Build a box aimed at a random node of the current tree, or a wild or empty one
  function automatic qbp_pkg::box_item_t make_box(box_shape_e shape);
    longint      nx0, nx1, ny0, ny1, mx, my;
    longint      xl, xh, yl, yh, x0, x1, y0, y1, t, d;
    int          depth;
    logic [1:0]  quad;
    if (shape == SHAPE_EMPTY) begin
      return pack_box(1'b0, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    if (shape == SHAPE_WILD) begin
      return pack_box(1'b1, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    nx0   = cx0;
    nx1   = cx1;
    ny0   = cy0;
    ny1   = cy1;
    depth = $urandom_range(0, MAX_DEPTH);
    for (int i = 0; i < depth; i++) begin
      mx   = (nx0 + nx1) / 2;
      my   = (ny0 + ny1) / 2;
      quad = 2'($urandom_range(0, 3));
      if (quad[0]) nx0 = mx; else nx1 = mx;
      if (quad[1]) ny0 = my; else ny1 = my;
    end
    xl = nx0 * EDGE_SCALE;
    xh = nx1 * EDGE_SCALE;
    yl = ny0 * EDGE_SCALE;
    yh = ny1 * EDGE_SCALE;
    if (xl > xh) begin
      t  = xl;
      xl = xh;
      xh = t;
    end
    if (yl > yh) begin
      t  = yl;
      yl = yh;
      yh = t;
    end
    x0 = pick_in(xl, xh);
    x1 = pick_in(x0, xh);
    y0 = pick_in(yl, yh);
    y1 = pick_in(y0, yh);
    // push one edge just past the node border
    if (shape == SHAPE_STRADDLE) begin
      d = rand_span(1, 2 * EDGE_SCALE);
      case ($urandom_range(0, 3))
        0: x0 = clamp_coord(x0 - d);
        1: x1 = clamp_coord(x1 + d);
        2: y0 = clamp_coord(y0 - d);
        default: y1 = clamp_coord(y1 + d);
      endcase
    end
    return pack_box(1'b1, x0, x1, y0, y1);
  endfunction

  // Random edges for one axis of the root square
  task automatic pick_axis(output longint lo, output longint hi);
    case ($urandom_range(0, 4))
      0: begin
        lo = rand_span(-20, 20);
        hi = lo + rand_span(0, 40);
      end
      1: begin
        lo = rand_span(EDGE_MIN, 0);
        hi = rand_span(0, EDGE_MAX);
      end
      2: begin
        lo = EDGE_MIN;
        hi = EDGE_MAX;
      end
      3: begin
        lo = rand_span(EDGE_MIN, EDGE_MAX);
        hi = rand_span(EDGE_MIN, EDGE_MAX);
      end
      default: begin
        lo = rand_span(-5000, 5000);
        hi = lo + rand_span(EDGE_SCALE, 40000);
      end
    endcase
    if (hi > EDGE_MAX) hi = EDGE_MAX;
  endtask

  // Offer one box, with an optional idle burst ahead of it
  task automatic offer_box(input qbp_pkg::box_item_t b, input bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) begin
      box_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    box_if.valid   <= 1'b1;
    box_if.payload <= b;
    @(posedge clk_i);
    while (!box_if.ready) @(posedge clk_i);
  endtask

  // Wait for every outstanding placement, then let the chain settle
  task automatic drain_results();
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (MAX_DEPTH + 2) @(posedge clk_i);
  endtask

  // Write the root square and depth limit, sometimes also a spare index
  task automatic write_config(input longint x0, input longint x1, input longint y0,
                              input longint y1, input int unsigned lvl);
    qbp_pkg::cfg_item_t          writes[$];
    qbp_pkg::cfg_item_t          w;
    logic [qbp_pkg::EDGE_W-1:0]  lvl_data;
    lvl_data                            = qbp_pkg::EDGE_W'($urandom);
    lvl_data[qbp_pkg::OUT_LVL_W-1:0]    = qbp_pkg::OUT_LVL_W'(lvl);
    writes = {writes, cfg_word(qbp_pkg::REG_ROOT_X_LOW,  qbp_pkg::EDGE_W'(x0))};
    writes = {writes, cfg_word(qbp_pkg::REG_ROOT_X_HIGH, qbp_pkg::EDGE_W'(x1))};
    writes = {writes, cfg_word(qbp_pkg::REG_ROOT_Y_LOW,  qbp_pkg::EDGE_W'(y0))};
    writes = {writes, cfg_word(qbp_pkg::REG_ROOT_Y_HIGH, qbp_pkg::EDGE_W'(y1))};
    if ($urandom_range(0, 2) == 0) begin
      writes = {writes,
                cfg_word(qbp_pkg::CFG_IDX_W'(REG_SPARE + $urandom_range(0, 2)),
                         qbp_pkg::EDGE_W'($urandom))};
    end
    writes = {writes, cfg_word(qbp_pkg::REG_MAX_LEVEL, lvl_data)};
    cx0 = longint'(qbp_pkg::edge_t'(x0));
    cx1 = longint'(qbp_pkg::edge_t'(x1));
    cy0 = longint'(qbp_pkg::edge_t'(y0));
    cy1 = longint'(qbp_pkg::edge_t'(y1));
    foreach (writes[i]) begin
      w              = writes[i];
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= w;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // One phase of random boxes, mostly aimed at nodes
  task automatic run_phase(input int n_items, input bit gaps);
    int unsigned r;
    box_shape_e  shape;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6)       shape = SHAPE_EMPTY;
      else if (r < 16) shape = SHAPE_WILD;
      else if (r < 36) shape = SHAPE_STRADDLE;
      else             shape = SHAPE_NODE;
      offer_box(make_box(shape), gaps);
    end
    box_if.valid <= 1'b0;
  endtask

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    place_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        place_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        place_if.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end else begin
        place_if.ready <= 1'b1;
      end
    end
  end

  // Abort when no channel moves an item for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((box_if.valid && box_if.ready) || (place_if.valid && place_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_quadtree_box_placement_core NOT OK");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    longint      x0, x1, y0, y1;
    int unsigned lvl;
    hold_off_req    = 1'b0;
    calm            = 1'b0;
    quiet_cycles    = 0;
    rst_ni         <= 1'b0;
    box_if.valid   <= 1'b0;
    box_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: depth limit 0 keeps everything at the root
    offer_box(pack_box(1'b1, -512000, -511990, -512000, -511990), 1'b0);
    offer_box(pack_box(1'b0, -1, -1, -1, -1), 1'b0);
    box_if.valid <= 1'b0;

    // default root, full depth
    drain_results();
    write_config(-2000, 2000, -2000, 2000, MAX_DEPTH);
    offer_box(pack_box(1'b0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX), 1'b0);
    offer_box(pack_box(1'b1, -512000, 512000, -512000, 512000), 1'b0);
    offer_box(pack_box(1'b1, -512000, -511990, -512000, -511990), 1'b0);
    offer_box(pack_box(1'b1, 511990, 512000, -512000, -511990), 1'b0);
    offer_box(pack_box(1'b1, -512000, -511990, 511990, 512000), 1'b0);
    offer_box(pack_box(1'b1, 511990, 512000, 511990, 512000), 1'b0);
    offer_box(pack_box(1'b1, 0, 0, 0, 0), 1'b0);
    offer_box(pack_box(1'b1, -512000, 0, -512000, 0), 1'b0);
    offer_box(pack_box(1'b1, -512001, -511000, -512000, -511000), 1'b0);
    offer_box(pack_box(1'b1, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX), 1'b0);
    offer_box(pack_box(1'b1, 1000, -1000, -1000, 1000), 1'b0);
    box_if.valid <= 1'b0;

    // widest root, depth limit above what the core supports
    drain_results();
    write_config(EDGE_MIN, EDGE_MAX, EDGE_MIN, EDGE_MAX, LEVEL_ALL_ONES);
    offer_box(pack_box(1'b1, COORD_MIN, COORD_MIN + 5, COORD_MIN, COORD_MIN + 5), 1'b0);
    offer_box(pack_box(1'b1, EDGE_MAX * EDGE_SCALE - 5, EDGE_MAX * EDGE_SCALE,
                       EDGE_MAX * EDGE_SCALE - 5, EDGE_MAX * EDGE_SCALE), 1'b0);
    offer_box(pack_box(1'b1, 0, COORD_MAX, 0, 100), 1'b0);
    offer_box(pack_box(1'b1, -128, -128, -128, -128), 1'b0);
    box_if.valid <= 1'b0;

    // inverted root on x
    drain_results();
    write_config(2000, -2000, -2000, 2000, MAX_DEPTH);
    offer_box(pack_box(1'b1, -512000, -511990, -512000, -511990), 1'b0);
    offer_box(pack_box(1'b1, 0, 0, 0, 0), 1'b0);
    box_if.valid <= 1'b0;

    // depth limit written as zero
    drain_results();
    write_config(-2000, 2000, -2000, 2000, 0);
    offer_box(pack_box(1'b1, 511990, 512000, 511990, 512000), 1'b0);
    offer_box(pack_box(1'b1, 0, 0, 0, 0), 1'b0);
    box_if.valid <= 1'b0;

    // random phases
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        x0  = -2000;
        x1  = 2000;
        y0  = -2000;
        y1  = 2000;
        lvl = MAX_DEPTH;
      end else begin
        pick_axis(x0, x1);
        pick_axis(y0, y1);
        if ($urandom_range(0, 9) < 7) lvl = $urandom_range(MAX_DEPTH - 3, MAX_DEPTH);
        else                          lvl = $urandom_range(0, LEVEL_ALL_ONES);
      end
      drain_results();
      write_config(x0, x1, y0, y1, lvl);
      // hold the result side long enough to back the chain up into the input
      if (p == 1) hold_off_req = 1'b1;
      calm = (p == RAND_PHASES - 1);
      run_phase(ITEMS_PER_PHASE, !calm);
    end

    drain_results();
    repeat (2 * MAX_DEPTH) @(posedge clk_i);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("tb_quadtree_box_placement_core OK");
    end else begin
      $display("tb_quadtree_box_placement_core NOT OK");
    end
    $finish;
  end

endmodule
